[hdl/matrix_multiply_engine_defines.svh]
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// Checks that a condition in this cycle implies another in the same cycle.
`define MME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition in this cycle implies another in the next cycle.
`define MME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mme_pkg.sv]
`default_nettype none

package mme_pkg;

  // Default sizing of the engine.
  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_ELEM_WIDTH = 16;

  // Fixed field widths.
  localparam int VALUE_W   = 40;
  localparam int RC_W      = 3;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

[hdl/matrix_multiply_engine.sv]
`default_nettype none

// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  ---------------------------------------------
// input     in         in_valid / in_ready   element_value
// output    out        out_valid / out_ready product_value, result_row, result_col, last_entry
// config    in         cfg_we (no wait)      cfg_index, cfg_data
//
// in_ready is high throughout loading. After the last B element, every entry of C is
// accumulated over inner_dim products on the single shared multiplier, and then the
// read, multiply and accumulate stages drain before the output is loaded, and the next
// entry starts only once that load has taken place.
// The stores need no clearing after reset; rst clears the sequencer and the load count.
// A stalled output holds the next entry's accumulation at the output load step.

module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire [CFG_IDX_W-1:0]         cfg_index,
  input  wire [DIM_W-1:0]             cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire signed [ELEM_WIDTH-1:0] element_value,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic signed [VALUE_W-1:0]   product_value,
  output logic [RC_W-1:0]             result_row,
  output logic [RC_W-1:0]             result_col,
  output logic                        last_entry
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = $clog2(2 * DEPTH + 1);
  localparam int PW    = 2 * ELEM_WIDTH;

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_MAC   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  // Clamp a register to the range 1..MAX_DIM.
  function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] r);
    logic [DW-1:0] d;
    if (r == '0) begin
      d = DW'(1);
    end else if (32'(r) > MAX_DIM) begin
      d = DW'(MAX_DIM);
    end else begin
      d = DW'(r);
    end
    return d;
  endfunction

  state_t                 state, state_next;
  logic [DIM_W-1:0]       rows_a, inner_dim, cols_b;
  logic [CW-1:0]          load_count, load_count_next;
  logic [IW-1:0]          idx_i, idx_i_next, idx_j, idx_j_next, idx_k, idx_k_next;
  logic [AW-1:0]          a_base, a_base_next, a_addr, a_addr_next, b_addr, b_addr_next;
  logic signed [VALUE_W-1:0] acc, acc_next;
  logic                   done_flag, done_flag_next;
  logic                   rd_v, rd_last, prod_v, prod_last;
  logic signed [ELEM_WIDTH-1:0] rd_a, rd_b;
  logic signed [PW-1:0]   prod;
  logic signed [ELEM_WIDTH-1:0] left_mem  [DEPTH];
  logic signed [ELEM_WIDTH-1:0] right_mem [DEPTH];

  logic [DW-1:0] ra, id, cb;
  logic [CW-1:0] a_len, total, pos;
  logic          in_xfer, out_free, emit, entry_last, k_last;

  assign ra       = eff_dim(rows_a);
  assign id       = eff_dim(inner_dim);
  assign cb       = eff_dim(cols_b);
  assign a_len    = CW'(ra) * CW'(id);
  assign total    = a_len + CW'(id) * CW'(cb);
  assign pos      = (load_count >= total) ? '0 : load_count;
  assign in_ready = (state == S_LOAD);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign k_last   = (idx_k == IW'(id - DW'(1)));
  assign entry_last = (idx_i == IW'(ra - DW'(1))) && (idx_j == IW'(cb - DW'(1)));
  assign emit     = (state == S_DRAIN) && done_flag && out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_W'(8);
      inner_dim <= DIM_W'(8);
      cols_b    <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Element stores, written while loading and read by the multiply sequencer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (pos < a_len) begin
        left_mem[AW'(pos)] <= element_value;
      end else begin
        right_mem[AW'(pos - a_len)] <= element_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MAC) begin
      rd_a <= left_mem[a_addr];
      rd_b <= right_mem[b_addr];
    end
  end

  // Shared multiplier stage.
  always_ff @(posedge clk) begin
    prod <= rd_a * rd_b;
  end

  // Pipeline control bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      prod_v    <= 1'b0;
      prod_last <= 1'b0;
    end else begin
      rd_v      <= (state == S_MAC);
      rd_last   <= (state == S_MAC) && k_last;
      prod_v    <= rd_v;
      prod_last <= rd_v && rd_last;
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    idx_i_next      = idx_i;
    idx_j_next      = idx_j;
    idx_k_next      = idx_k;
    a_base_next     = a_base;
    a_addr_next     = a_addr;
    b_addr_next     = b_addr;
    acc_next        = acc;
    done_flag_next  = done_flag;

    if (prod_v) begin
      acc_next = acc + VALUE_W'(prod);
    end
    if (prod_v && prod_last) begin
      done_flag_next = 1'b1;
    end

    case (state)
      S_LOAD: begin
        if (in_xfer) begin
          if (pos + CW'(1) >= total) begin
            load_count_next = '0;
            idx_i_next      = '0;
            idx_j_next      = '0;
            idx_k_next      = '0;
            a_base_next     = '0;
            a_addr_next     = '0;
            b_addr_next     = '0;
            acc_next        = '0;
            done_flag_next  = 1'b0;
            state_next      = S_MAC;
          end else begin
            load_count_next = pos + CW'(1);
          end
        end
      end
      S_MAC: begin
        idx_k_next  = idx_k + IW'(1);
        a_addr_next = a_addr + AW'(1);
        b_addr_next = b_addr + AW'(cb);
        if (k_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (emit) begin
          acc_next       = '0;
          done_flag_next = 1'b0;
          idx_k_next     = '0;
          if (entry_last) begin
            state_next = S_LOAD;
          end else begin
            state_next = S_MAC;
            if (idx_j == IW'(cb - DW'(1))) begin
              idx_j_next  = '0;
              idx_i_next  = idx_i + IW'(1);
              a_base_next = a_base + AW'(id);
              a_addr_next = a_base + AW'(id);
              b_addr_next = '0;
            end else begin
              idx_j_next  = idx_j + IW'(1);
              a_addr_next = a_base;
              b_addr_next = AW'(idx_j + IW'(1));
            end
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase

    // A register write restarts loading.
    if (cfg_we) begin
      load_count_next = '0;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      done_flag  <= 1'b0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      done_flag  <= done_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_i  <= idx_i_next;
    idx_j  <= idx_j_next;
    idx_k  <= idx_k_next;
    a_base <= a_base_next;
    a_addr <= a_addr_next;
    b_addr <= b_addr_next;
    acc    <= acc_next;
  end

  // Output register; the next entry computes while this one waits for a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      product_value <= acc;
      result_row    <= RC_W'(idx_i);
      result_col    <= RC_W'(idx_j);
      last_entry    <= entry_last;
    end
  end

endmodule

`default_nettype wire

[hdl/mme_checker.sv]
`default_nettype none

`include "matrix_multiply_engine_defines.svh"

module mme_assertions
  import mme_pkg::*;
(
  input wire                       clk,
  input wire                       rst,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire signed [VALUE_W-1:0]  product_value,
  input wire [RC_W-1:0]            result_row,
  input wire [RC_W-1:0]            result_col,
  input wire                       last_entry
);

  // A stalled result holds its contents.
  `MME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(product_value) && $stable(result_row) && $stable(result_col) && $stable(last_entry), "stalled result changed")

  // The final entry of a run is followed by a gap before any new result.
  `MME_ASSERT_NEXT(a_gap_after_last, out_valid && out_ready && last_entry, !out_valid, "result right after the final entry")

  // Accepting an element never produces a result in the next cycle.
  `MME_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result directly after an element transfer")

  // Loading stays closed until the final entry of a run has been presented.
  `MME_ASSERT_NEXT(a_busy_mid_run, out_valid && out_ready && !last_entry, out_valid || !in_ready, "input open in the middle of a run")

endmodule

bind matrix_multiply_engine mme_assertions u_mme_checker (.*);

`default_nettype wire

[verif/mme_checker.sv]
`timescale 1ns / 100ps

module mme_checker
  import mme_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [DIM_W-1:0]                 cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic signed [DEF_ELEM_WIDTH-1:0] element_value,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic signed [VALUE_W-1:0]        product_value,
  input  logic [RC_W-1:0]                  result_row,
  input  logic [RC_W-1:0]                  result_col,
  input  logic                             last_entry,
  output int                               error_count,
  output int                               pending_count
);

  localparam int STORE_DEPTH = DEF_MAX_DIM * DEF_MAX_DIM;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [RC_W-1:0]           row;
    logic [RC_W-1:0]           col;
    logic                      last;
  } entry_t;

  // Shadow copy of the engine's registers and element stores.
  logic [DIM_W-1:0]                 rows_reg;
  logic [DIM_W-1:0]                 inner_reg;
  logic [DIM_W-1:0]                 cols_reg;
  logic signed [DEF_ELEM_WIDTH-1:0] left_store [STORE_DEPTH];
  logic signed [DEF_ELEM_WIDTH-1:0] right_store [STORE_DEPTH];
  int                               load_count;
  int                               errors;
  entry_t                           expected_entries [$];

  initial begin
    error_count   = 0;
    pending_count = 0;
    errors        = 0;
  end

  // A zero dimension acts as one and anything above the maximum is clipped.
  function automatic int clamp_dim(logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(raw);
  endfunction

  // Store one element; the last element of B queues every entry of C in row-major order.
  function automatic void load_element(logic signed [DEF_ELEM_WIDTH-1:0] v);
    int ra;
    int id;
    int cb;
    int a_len;
    int total;
    int pos;
    logic signed [VALUE_W-1:0] acc;
    entry_t e;
    ra    = clamp_dim(rows_reg);
    id    = clamp_dim(inner_reg);
    cb    = clamp_dim(cols_reg);
    a_len = ra * id;
    total = a_len + id * cb;
    pos   = (load_count >= total) ? 0 : load_count;
    if (pos < a_len) left_store[pos] = v;
    else right_store[pos - a_len] = v;
    pos++;
    if (pos < total) begin
      load_count = pos;
      return;
    end
    load_count = 0;
    for (int i = 0; i < ra; i++) begin
      for (int j = 0; j < cb; j++) begin
        acc = '0;
        for (int k = 0; k < id; k++) begin
          acc += left_store[i * id + k] * right_store[k * cb + j];
        end
        e.value = acc;
        e.row   = i[RC_W-1:0];
        e.col   = j[RC_W-1:0];
        e.last  = (i == ra - 1) && (j == cb - 1);
        expected_entries.push_back(e);
      end
    end
  endfunction

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    entry_t head;
    if (rst) begin
      rows_reg   = 4'd8;
      inner_reg  = 4'd8;
      cols_reg   = 4'd8;
      load_count = 0;
      expected_entries.delete();
    end else begin
      // Compare a result transfer against the oldest expected entry.
      if (out_valid && out_ready) begin
        if (expected_entries.size() == 0) begin
          $error("result transfer with nothing expected: row %0d col %0d value %0d",
                 result_row, result_col, product_value);
          errors++;
        end else begin
          head = expected_entries.pop_front();
          if (product_value !== head.value) begin
            $error("product_value: expected %0d, actual %0d", head.value, product_value);
            errors++;
          end
          if (result_row !== head.row) begin
            $error("result_row: expected %0d, actual %0d", head.row, result_row);
            errors++;
          end
          if (result_col !== head.col) begin
            $error("result_col: expected %0d, actual %0d", head.col, result_col);
            errors++;
          end
          if (last_entry !== head.last) begin
            $error("last_entry: expected %0d, actual %0d", head.last, last_entry);
            errors++;
          end
        end
      end

      // Any register write, even to the unused index, restarts loading.
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_A:    rows_reg  = cfg_data;
          REG_INNER_DIM: inner_reg = cfg_data;
          REG_COLS_B:    cols_reg  = cfg_data;
          default: ;
        endcase
        load_count = 0;
      end

      if (in_valid && in_ready) load_element(element_value);
    end
    error_count   <= errors;
    pending_count <= expected_entries.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mme_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_ITEMS   = 200;

  logic                             clk           = 1'b0;
  logic                             rst           = 1'b1;
  logic                             cfg_we        = 1'b0;
  cfg_reg_t                         cfg_index     = REG_ROWS_A;
  logic [DIM_W-1:0]                 cfg_data      = '0;
  logic                             in_valid      = 1'b0;
  logic signed [DEF_ELEM_WIDTH-1:0] element_value = '0;
  logic                             out_ready     = 1'b0;
  logic                             in_ready;
  logic                             out_valid;
  logic signed [VALUE_W-1:0]        product_value;
  logic [RC_W-1:0]                  result_row;
  logic [RC_W-1:0]                  result_col;
  logic                             last_entry;
  int                               error_count;
  int                               pending_count;
  int                               idle_cycles   = 0;
  int                               ready_hold    = 0;
  int                               random_items  = 0;
  bit                               steady_input  = 1'b0;

  always #5 clk = ~clk;

  matrix_multiply_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_value (product_value),
    .result_row    (result_row),
    .result_col    (result_col),
    .last_entry    (last_entry)
  );

  mme_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_value (product_value),
    .result_row    (result_row),
    .result_col    (result_col),
    .last_entry    (last_entry),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  // Result side backpressure: long ready stretches, mostly short stalls, a few long ones.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      if (out_ready) begin
        out_ready  <= 1'b0;
        ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      end else begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(1, 60);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // Watchdog on cycles without any transfer or register write.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int eff_dim(logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DEF_MAX_DIM) return DEF_MAX_DIM;
    return int'(raw);
  endfunction

  // Mostly back-to-back or short gaps, with the occasional long pause.
  function automatic int pick_gap();
    int r;
    if (steady_input) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Field extremes show up often; the rest is uniform over all 16 bits.
  function automatic logic signed [DEF_ELEM_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return DEF_ELEM_WIDTH'($urandom);
    endcase
  endfunction

  // Present one element and hold it until the transfer happens.
  task automatic send_element(input logic signed [DEF_ELEM_WIDTH-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_element(pick_value());
  endtask

  // Drop valid, then wait for every expected entry plus a margin for the engine to go idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] i,
                          input logic [DIM_W-1:0] c);
    write_reg(REG_ROWS_A, r);
    write_reg(REG_INNER_DIM, i);
    write_reg(REG_COLS_B, c);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 3) != 0) return DIM_W'($urandom_range(1, 3));
    return DIM_W'($urandom_range(0, 15));
  endfunction

  initial begin
    int run_len;
    int partial;
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] i;
    logic [DIM_W-1:0] c;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Zero dimensions act as one: three 1x1 products, mostly at the value extremes.
    set_dims(4'd0, 4'd0, 4'd0);
    send_element(16'sh8000);
    send_element(16'sh8000);
    send_element(16'sh7fff);
    send_element(16'sh8000);
    send_element(16'sh0000);
    send_element(16'sh0100);
    settle();

    // A write to the unused index in the middle of a load restarts it.
    send_element(16'sh7fff);
    settle();
    write_reg(REG_UNUSED, 4'hf);
    send_element(16'sh0100);
    send_element(16'sh0200);
    settle();

    // Small 1x2 by 2x2 product with mixed signs.
    set_dims(4'd1, 4'd2, 4'd2);
    send_element(16'sh8000);
    send_element(16'sh7fff);
    send_element(16'sh7fff);
    send_element(16'sh8000);
    send_element(16'shffff);
    send_element(16'sh0001);
    settle();

    // An oversized column count is clipped to the maximum.
    set_dims(4'd1, 4'd1, 4'd15);
    send_random(9);
    settle();

    // One full-size product, then random shapes, repeats and aborted loads.
    r = 4'd8;
    i = 4'd15;
    c = 4'd8;
    set_dims(r, i, c);
    send_random(128);
    random_items += 128;
    settle();
    while (random_items < RANDOM_ITEMS) begin
      steady_input = ($urandom_range(0, 3) == 0);
      // Sometimes abandon a partial load under the current shape.
      if ($urandom_range(0, 3) == 0) begin
        run_len = eff_dim(r) * eff_dim(i) + eff_dim(i) * eff_dim(c);
        if (run_len > 1) begin
          partial = $urandom_range(1, run_len - 1);
          send_random(partial);
          random_items += partial;
          settle();
        end
      end
      if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, DIM_W'($urandom));
      r = pick_dim();
      i = pick_dim();
      c = pick_dim();
      set_dims(r, i, c);
      run_len = eff_dim(r) * eff_dim(i) + eff_dim(i) * eff_dim(c);
      repeat ($urandom_range(1, 3)) begin
        send_random(run_len);
        random_items += run_len;
      end
      settle();
    end

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
